>>> rtl/core/rrw_pkg.sv
// Shared types and constants of the receive reorder window.
package rrw_pkg;

  localparam int ID_W = 32;
  localparam int TAG_W = 16;
  localparam int ACT_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int WINDOW_SLOTS_DEF = 4;

  localparam logic [ID_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;
  localparam logic [ID_W-1:0] LAST_SEQ_RESET = 32'hFFFF_FFFD;
  localparam logic [ID_W-1:0] UPD_ONLY_RESET = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_LAST_SEQ = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPD_ONLY = 4'd1;

  localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DUP_ACK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STORED = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROPPED = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UPD_ONLY = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    logic             is_data;
  } entry_t;

  typedef struct packed {
    logic store_en;
    logic drain_en;
  } cell_ctl_t;

endpackage

>>> rtl/core/rrw_rx_if.sv
// Receive channel: one buffer descriptor per beat.
interface rrw_rx_if;
  logic                     valid;
  logic                     ready;
  logic [rrw_pkg::ID_W-1:0]  buffer_id;
  logic [rrw_pkg::TAG_W-1:0] buffer_tag;
  logic                     is_data;
  logic                     has_updates;

  modport source (output valid, buffer_id, buffer_tag, is_data, has_updates, input ready);
  modport sink (input valid, buffer_id, buffer_tag, is_data, has_updates, output ready);
endinterface

>>> rtl/core/rrw_tx_if.sv
// Result channel: one reorder decision per beat.
interface rrw_tx_if;
  logic                     valid;
  logic                     ready;
  logic [rrw_pkg::ACT_W-1:0] action;
  logic [rrw_pkg::ID_W-1:0]  out_id;
  logic [rrw_pkg::TAG_W-1:0] out_tag;
  logic                     parse_payload;
  logic                     free_sent;
  logic                     record_ack;
  logic                     last;

  modport source (output valid, action, out_id, out_tag, parse_payload, free_sent,
                  record_ack, last, input ready);
  modport sink (input valid, action, out_id, out_tag, parse_payload, free_sent,
                record_ack, last, output ready);
endinterface

>>> rtl/core/rrw_cfg_if.sv
// Configuration write channel: register index and data per beat.
interface rrw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrw_pkg::CFG_IDX_W-1:0] index;
  logic [rrw_pkg::ID_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rrw_cell.sv
// One slot of the out-of-order store, chained to its neighbours.
module rrw_cell #(
  parameter int SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
  parameter int INDEX = 0,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                     clk,
  input  logic [rrw_pkg::ID_W-1:0] exp_id,
  input  logic [CW-1:0]            count,
  input  rrw_pkg::cell_ctl_t       ctl,
  input  rrw_pkg::entry_t          new_entry,
  input  rrw_pkg::entry_t          tail_entry,
  input  logic                     hit_in,
  output logic                     hit_out,
  input  rrw_pkg::entry_t          tail_in,
  output rrw_pkg::entry_t          tail_out,
  input  rrw_pkg::entry_t          found_in,
  output rrw_pkg::entry_t          found_out
);
  import rrw_pkg::*;

  entry_t entry;
  logic   active;
  logic   my_hit;
  logic   take;
  logic   is_tail;

  assign active  = count > CW'(INDEX);
  assign my_hit  = active && (entry.id == exp_id);
  // lowest filled slot that matches wins
  assign take    = my_hit && !hit_in;
  assign hit_out = hit_in || my_hit;
  assign is_tail = count == CW'(INDEX + 1);
  assign tail_out  = is_tail ? entry : tail_in;
  assign found_out = take ? entry : found_in;

  always_ff @(posedge clk) begin
    if (ctl.store_en && (count == CW'(INDEX))) begin
      entry <= new_entry;
    end else if (ctl.drain_en && take) begin
      // refill the freed slot with the last filled one
      entry <= tail_entry;
    end
  end

endmodule

>>> rtl/core/receive_reorder_window_unit.sv
// Top level of the receive reorder window: id check, FSM and cell chain.
//
//  channel | dir | beat carries
//  rx      | in  | buffer_id, buffer_tag, is_data, has_updates
//  tx      | out | action, out_id, out_tag, parse_payload, free_sent, record_ack, last
//  cfg     | in  | index, data (0 last_sequence_id, 1 update_only_id)
//
// A duplicate, stored, dropped or update-only buffer gives its result in the
// output register. An expected buffer is delivered from the drain state with its
// following slots: the cell chain finds one matching slot per cycle unless tx stalls.
// rst is synchronous; it clears the expected id, the fill count and the FSM.
// A stalled tx holds the result and rx ready drops until the register frees.
module receive_reorder_window_unit #(
  parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF
) (
  input logic  clk,
  input logic  rst,
  rrw_rx_if.sink   rx,
  rrw_tx_if.source tx,
  rrw_cfg_if.sink  cfg
);
  import rrw_pkg::*;

  localparam int CW = $clog2(WINDOW_SLOTS + 1);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t              state;
  logic [ID_W-1:0]     last_seq;
  logic [ID_W-1:0]     upd_only;
  logic [ID_W-1:0]     expected;
  logic [CW-1:0]       count;

  entry_t              pend;
  logic                pend_free;
  logic                pend_ack;

  logic                out_valid;
  logic [ACT_W-1:0]    out_action;
  logic [ID_W-1:0]     out_id;
  logic [TAG_W-1:0]    out_tag;
  logic                out_parse;
  logic                out_free;
  logic                out_ack;
  logic                out_last;

  logic                slot_open;
  logic                rx_fire;
  logic [ID_W-1:0]     diff;
  logic [ID_W-1:0]     expected_next;
  logic                hit_exp;
  logic                older;
  logic                regular;
  logic                full;
  logic                any_hit;
  cell_ctl_t           ctl;
  entry_t              new_entry;
  entry_t              tail_entry;
  entry_t              found_entry;

  logic   hit_c   [WINDOW_SLOTS+1];
  entry_t tail_c  [WINDOW_SLOTS+1];
  entry_t found_c [WINDOW_SLOTS+1];

  assign slot_open = !out_valid || tx.ready;
  assign rx.ready  = (state == ST_IDLE) && slot_open;
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  assign diff          = expected - rx.buffer_id;
  assign hit_exp       = rx.buffer_id == expected;
  assign older         = (diff != '0) && (diff <= HALF_RANGE);
  assign regular       = rx.buffer_id <= last_seq;
  assign full          = count == CW'(WINDOW_SLOTS);
  assign expected_next = (expected >= last_seq) ? '0 : expected + 32'd1;

  assign new_entry = '{id: rx.buffer_id, tag: rx.buffer_tag, is_data: rx.is_data};
  assign ctl.store_en = rx_fire && !hit_exp && !older && regular && !full;
  assign ctl.drain_en = (state == ST_DRAIN) && slot_open;

  assign hit_c[0]   = 1'b0;
  assign tail_c[0]  = '0;
  assign found_c[0] = '0;

  for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
    rrw_cell #(.SLOTS(WINDOW_SLOTS), .INDEX(g)) u_cell (
      .clk        (clk),
      .exp_id     (expected),
      .count      (count),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .tail_entry (tail_entry),
      .hit_in     (hit_c[g]),
      .hit_out    (hit_c[g+1]),
      .tail_in    (tail_c[g]),
      .tail_out   (tail_c[g+1]),
      .found_in   (found_c[g]),
      .found_out  (found_c[g+1])
    );
  end

  assign any_hit     = hit_c[WINDOW_SLOTS];
  assign tail_entry  = tail_c[WINDOW_SLOTS];
  assign found_entry = found_c[WINDOW_SLOTS];

  assign tx.valid         = out_valid;
  assign tx.action        = out_action;
  assign tx.out_id        = out_id;
  assign tx.out_tag       = out_tag;
  assign tx.parse_payload = out_parse;
  assign tx.free_sent     = out_free;
  assign tx.record_ack    = out_ack;
  assign tx.last          = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      expected  <= '0;
      count     <= '0;
      last_seq  <= LAST_SEQ_RESET;
      upd_only  <= UPD_ONLY_RESET;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_LAST_SEQ: last_seq <= cfg.data;
          REG_UPD_ONLY: upd_only <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (rx_fire) begin
            out_id    <= rx.buffer_id;
            out_tag   <= rx.buffer_tag;
            out_parse <= 1'b0;
            out_last  <= 1'b1;
            if (hit_exp) begin
              // hold the delivery until the chain says whether more follow
              out_valid <= 1'b0;
              pend      <= new_entry;
              pend_free <= rx.has_updates;
              pend_ack  <= 1'b1;
              expected  <= expected_next;
              state     <= ST_DRAIN;
            end else if (older) begin
              out_valid  <= 1'b1;
              out_action <= ACT_DUP_ACK;
              out_free   <= 1'b0;
              out_ack    <= 1'b1;
            end else if (regular) begin
              out_valid <= 1'b1;
              out_free  <= rx.has_updates;
              if (!full) begin
                out_action <= ACT_STORED;
                out_ack    <= 1'b1;
                count      <= count + CW'(1);
              end else begin
                out_action <= ACT_DROPPED;
                out_ack    <= 1'b0;
              end
            end else if (rx.buffer_id == upd_only) begin
              out_valid  <= 1'b1;
              out_action <= ACT_UPD_ONLY;
              out_free   <= 1'b1;
              out_ack    <= 1'b0;
            end else begin
              out_valid <= 1'b0;
            end
          end else if (tx.ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (slot_open) begin
            out_valid  <= 1'b1;
            out_action <= ACT_DELIVER;
            out_id     <= pend.id;
            out_tag    <= pend.tag;
            out_parse  <= pend.is_data;
            out_free   <= pend_free;
            out_ack    <= pend_ack;
            out_last   <= !any_hit;
            if (any_hit) begin
              // advance: the matching slot becomes the next pending delivery
              pend      <= found_entry;
              pend_free <= 1'b0;
              pend_ack  <= 1'b0;
              count     <= count - CW'(1);
              expected  <= expected_next;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
